// File: sv/sorted_unique_set_defines.svh
// Assertion macros used by the sorted unique set design.
`ifndef SORTED_UNIQUE_SET_DEFINES_SVH
`define SORTED_UNIQUE_SET_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SUS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted unique set check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SUS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted unique set check failed");

`endif

// File: sv/sus_pkg.sv
// Types, request and status codes, and default sizes of the sorted unique set.
package sus_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 32;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_REMOVED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_READ_OK   = 3'd5;
	localparam logic [2:0] ST_BEYOND    = 3'd6;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] key;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] read_value;
		logic [4:0]         entry_count;
	} rsp_t;

endpackage

// File: sv/sus_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sus_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/sorted_unique_set.sv
// A read fetches the key at its position through the registered RAM read port (S_FETCH)
// and then loads its result (S_DONE); a read beyond the count skips the fetch. An insert or
// remove scans the store through the RAM read port, alternating S_SCAN and S_CHECK per entry
// until the key's place is found, then moves one entry per cycle in S_SHIFT to open or close
// the gap. One item is handled at a time; the next item is accepted in the cycle after the
// result is loaded, even while that result waits. Reset clears the key count and the
// handshake state; the key RAM is not cleared.
module sorted_unique_set #(
	parameter int CAPACITY  = sus_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = sus_pkg::KEY_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sus_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sus_pkg::rsp_t rsp
);

	import sus_pkg::*;

	`include "sorted_unique_set_defines.svh"

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FETCH = 6'b000010,
		S_SCAN  = 6'b000100,
		S_CHECK = 6'b001000,
		S_SHIFT = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [1:0]             req_type_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          rd_q;
	logic                   wp_q;
	logic [AW-1:0]          wa_q;
	logic [2:0]             status_q;
	logic signed [31:0]     value_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [KEY_WIDTH-1:0]   ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [KEY_WIDTH-1:0]   ram_rdata;

	logic signed [KEY_WIDTH-1:0] rd_key;
	logic signed [KEY_WIDTH-1:0] in_key;
	logic [CW-1:0]          rd_dec;
	logic                   accept;
	logic                   pos_ok;
	logic                   scan_end;
	logic                   present;
	logic                   put_key;
	logic                   shift_move;
	logic                   rsp_load;

	assign accept  = req_valid && !req_stall;
	assign rd_key  = $signed(ram_rdata);
	assign in_key  = KEY_WIDTH'($signed(req.key[EW-1:0]));
	assign rd_dec  = rd_q - 1'b1;
	assign pos_ok  = (32'(req.position) < 32'(count_q)) && (32'(req.position) < CAPACITY);
	assign present = (state_q == S_CHECK) && (rd_key == key_q);
	assign scan_end = ((state_q == S_SCAN) && (idx_q == count_q)) ||
		((state_q == S_CHECK) && !(rd_key < key_q));
	assign put_key = (state_q == S_SHIFT) && (req_type_q == REQ_INSERT) &&
		(rd_q == idx_q) && !wp_q;
	assign shift_move = (state_q == S_SHIFT) &&
		((req_type_q == REQ_INSERT) ? (rd_q != idx_q) : (rd_q != count_q));
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = ram_rdata;
		if (wp_q) begin
			ram_we = 1'b1;
		end else if (put_key) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q[AW-1:0];
			ram_wdata = key_q;
		end
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:  ram_raddr = AW'(req.position);
			S_SHIFT: ram_raddr = (req_type_q == REQ_INSERT) ? rd_dec[AW-1:0] : rd_q[AW-1:0];
			default: ram_raddr = idx_q[AW-1:0];
		endcase
	end

	sus_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_keys (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			wp_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wp_q <= shift_move;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_type_q <= req.req_type;
						key_q      <= in_key;
						idx_q      <= '0;
						value_q    <= '0;
						if (req.req_type == REQ_INSERT || req.req_type == REQ_REMOVE) begin
							state_q <= S_SCAN;
						end else if (pos_ok) begin
							state_q <= S_FETCH;
						end else begin
							status_q <= ST_BEYOND;
							state_q  <= S_DONE;
						end
					end
				end
				S_FETCH: begin
					status_q <= ST_READ_OK;
					value_q  <= 32'($signed(ram_rdata));
					state_q  <= S_DONE;
				end
				S_SCAN, S_CHECK: begin
					if (scan_end) begin
						if (req_type_q == REQ_INSERT) begin
							if (present) begin
								status_q <= ST_PRESENT;
								state_q  <= S_DONE;
							end else if (32'(count_q) == CAPACITY) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								rd_q    <= count_q;
								state_q <= S_SHIFT;
							end
						end else begin
							if (!present) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_DONE;
							end else begin
								rd_q    <= idx_q + 1'b1;
								state_q <= S_SHIFT;
							end
						end
					end else if (state_q == S_SCAN) begin
						state_q <= S_CHECK;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SHIFT: begin
					if (req_type_q == REQ_INSERT) begin
						if (rd_q != idx_q) begin
							wa_q <= rd_q[AW-1:0];
							rd_q <= rd_dec;
						end else if (!wp_q) begin
							count_q  <= count_q + 1'b1;
							status_q <= ST_INSERTED;
							state_q  <= S_DONE;
						end
					end else begin
						if (rd_q != count_q) begin
							wa_q <= rd_dec[AW-1:0];
							rd_q <= rd_q + 1'b1;
						end else if (!wp_q) begin
							count_q  <= count_q - 1'b1;
							status_q <= ST_REMOVED;
							state_q  <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q.status      <= status_q;
						rsp_q.read_value  <= value_q;
						rsp_q.entry_count <= 5'(count_q);
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SUS_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= CAPACITY)
	`SUS_ASSERT_NOW(a_wp_in_shift, wp_q, state_q == S_SHIFT)
	`SUS_ASSERT_NEXT(a_count_only_in_shift, state_q != S_SHIFT, $stable(count_q))
	`SUS_ASSERT_NOW(a_put_after_drain, put_key, !wp_q && (32'(count_q) < CAPACITY))

endmodule
